@@ rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Holds the transfer payload structs, node record, cell control and command codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int CapacityDefault = 16;
    localparam int Slots           = 6;

    localparam int KeyW    = 21;
    localparam int CostW   = 20;
    localparam int LevelW  = 4;
    localparam int AssignW = 3 * Slots;
    localparam int OccW    = 5;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]                command;
        logic [KeyW-1:0]           estimate;
        logic [CostW-1:0]          lower_bound;
        logic [CostW-1:0]          upper_bound;
        logic [CostW-1:0]          current_cost;
        logic signed [LevelW-1:0]  depth_level;
        logic [AssignW-1:0]        assignment;
    } req_t;

    typedef struct packed {
        logic                      is_empty;
        logic                      is_full;
        logic                      dropped;
        logic [OccW-1:0]           occupancy;
        logic [KeyW-1:0]           top_estimate;
        logic [CostW-1:0]          top_lower;
        logic [CostW-1:0]          top_upper;
        logic [CostW-1:0]          top_cost;
        logic signed [LevelW-1:0]  top_level;
        logic [AssignW-1:0]        top_assignment;
    } rsp_t;

    typedef struct packed {
        logic [KeyW-1:0]    key;
        logic [CostW-1:0]   lower;
        logic [CostW-1:0]   upper;
        logic [CostW-1:0]   cost;
        logic [LevelW-1:0]  level;
        logic [AssignW-1:0] assign_bits;
    } node_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
// One slot of the sorted chain: holds a node and trades it with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic                   clk,
    input  wire spq_pkg::cell_ctrl_t    ctrl,
    input  wire logic                   in_use,
    input  wire logic                   left_keep,
    input  wire spq_pkg::node_t         new_node,
    input  wire spq_pkg::node_t         left_node,
    input  wire spq_pkg::node_t         right_node,
    output logic                        keep,
    output spq_pkg::node_t              node,
    output spq_pkg::node_t              node_next
);

    spq_pkg::node_t node_reg;

    // A stored node stays put on a push when it outranks the incoming key.
    assign keep = in_use && (node_reg.key > new_node.key);

    always_comb
    begin
        node_next = node_reg;
        if (ctrl.push && !keep)
        begin
            node_next = left_keep ? new_node : left_node;
        end
        else if (ctrl.pop)
        begin
            node_next = right_node;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
    end

    assign node = node_reg;

endmodule

`default_nettype wire

@@ rtl/spq_obuf.sv @@
// Output register with a skid stage for the result channel.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_obuf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire spq_pkg::rsp_t  load_data,
    output logic                full,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output spq_pkg::rsp_t       rsp_data
);

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    spq_pkg::rsp_t out_data_reg, out_data_next;
    spq_pkg::rsp_t skid_data_reg, skid_data_next;
    logic          out_free;

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = load_data;
                out_valid_next = load;
            end
        end
        else if (load)
        begin
            skid_data_next  = load_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: a chain of node cells plus an output buffer.
// Depends on spq_pkg, spq_cell and spq_obuf.
//
//   Channel  Direction  Handshake        Payload
//   req      in         req_valid/stall  spq_pkg::req_t (command and node)
//   rsp      out        rsp_valid/stall  spq_pkg::rsp_t (status and top node)
//
// Each accepted request updates the whole chain in the cycle it is accepted, so
// one transfer per cycle holds while req_stall is low; results are registered.
// The request side stalls only while the skid stage behind the output register
// is occupied, which happens after the result side has stalled.
// Reset clears the node count and the handshake state; cell contents are left
// as they are and are never shown until a push has written them.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CapacityDefault
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire spq_pkg::req_t  req_data,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output spq_pkg::rsp_t       rsp_data
);

    localparam int CntW = $clog2(CAPACITY + 1);

    logic                  req_accept;
    logic                  buf_full;
    logic [CntW-1:0]       count_reg, count_next;
    logic                  is_full_now;
    logic                  is_empty_now;
    logic                  do_push;
    logic                  do_pop;
    logic                  dropped;
    spq_pkg::cell_ctrl_t   ctrl;
    spq_pkg::node_t        new_node;
    spq_pkg::node_t        cell_node [CAPACITY];
    spq_pkg::node_t        cell_next [CAPACITY];
    logic                  cell_keep [CAPACITY];
    spq_pkg::rsp_t         result;

    assign req_stall  = buf_full;
    assign req_accept = req_valid && !buf_full;

    assign is_full_now  = (count_reg == CntW'(CAPACITY));
    assign is_empty_now = (count_reg == '0);

    // Decode the command. The unused code behaves as no operation.
    always_comb
    begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        dropped = 1'b0;
        case (spq_pkg::cmd_t'(req_data.command))
            spq_pkg::CMD_PUSH:
            begin
                do_push = req_accept && !is_full_now;
                dropped = is_full_now;
            end
            spq_pkg::CMD_POP:
            begin
                do_pop = req_accept && !is_empty_now;
            end
            default:
            begin
                do_push = 1'b0;
            end
        endcase
    end

    assign ctrl.push = do_push;
    assign ctrl.pop  = do_pop;

    assign new_node.key         = req_data.estimate;
    assign new_node.lower       = req_data.lower_bound;
    assign new_node.upper       = req_data.upper_bound;
    assign new_node.cost        = req_data.current_cost;
    assign new_node.level       = req_data.depth_level;
    assign new_node.assign_bits = req_data.assignment;

    // The chain: a push shifts every cell from the insertion point one place down,
    // a pop shifts every cell one place up. Each cell decides from its own key and
    // the keep flag of its upper neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic            left_keep;
        spq_pkg::node_t  left_node;
        spq_pkg::node_t  right_node;

        if (i == 0)
        begin : g_head
            assign left_keep = 1'b1;
            assign left_node = new_node;
        end
        else
        begin : g_body
            assign left_keep = cell_keep[i-1];
            assign left_node = cell_node[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_node = new_node;
        end
        else
        begin : g_mid
            assign right_node = cell_node[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .in_use     (CntW'(i) < count_reg),
            .left_keep  (left_keep),
            .new_node   (new_node),
            .left_node  (left_node),
            .right_node (right_node),
            .keep       (cell_keep[i]),
            .node       (cell_node[i]),
            .node_next  (cell_next[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // The result reflects the queue after this transfer; top fields read as zero
    // when nothing is stored.
    always_comb
    begin
        result                = '0;
        result.is_empty       = (count_next == '0);
        result.is_full        = (count_next == CntW'(CAPACITY));
        result.dropped        = dropped;
        result.occupancy      = spq_pkg::OccW'(count_next);
        if (count_next != '0)
        begin
            result.top_estimate   = cell_next[0].key;
            result.top_lower      = cell_next[0].lower;
            result.top_upper      = cell_next[0].upper;
            result.top_cost       = cell_next[0].cost;
            result.top_level      = cell_next[0].level;
            result.top_assignment = cell_next[0].assign_bits;
        end
    end

    spq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (req_accept),
        .load_data (result),
        .full      (buf_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

@@ rtl/spq_check.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module spq_check (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire spq_pkg::rsp_t rsp_data,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.is_empty == (rsp_data.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.dropped |-> rsp_data.is_full && !rsp_data.is_empty)
        else $error("push dropped while queue not full");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.is_empty |-> rsp_data.top_estimate == '0)
        else $error("empty queue shows a top key");

    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("accepted request produced no result");

endmodule

bind sorted_priority_queue spq_check u_spq_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
);

`default_nettype wire
